// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SEM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define SEM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== design/sem_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude core.
// Depends on nothing.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;

  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 13;
  localparam logic [CfgWidthBits-1:0]  WidthReset  = 11'd640;
  localparam logic [CfgHeightBits-1:0] HeightReset = 13'd480;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam int PixBits = 24;
  localparam logic [20:0] SatLimit = 21'd65280;
  localparam logic [7:0]  PixMax   = 8'd255;

  localparam int KX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KY [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  typedef logic [2:0][2:0][PixBits-1:0] sem_win_t;

  // One window to evaluate, with the taps that lie inside the image.
  typedef struct packed {
    sem_win_t win;
    logic     top_ok;
    logic     bot_ok;
    logic     lft_ok;
    logic     rgt_ok;
    logic     frame_end;
  } sem_job_t;

endpackage

// ===== design/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sem_front.sv =====
// Front end: accepts words, keeps line buffers, window and frame counters,
// and issues evaluation jobs. Depends on sem_pkg, sem_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sem_front import sem_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  localparam int WW = $clog2(MaxWidth + 2),
  localparam int HW = $clog2(MaxHeight + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               kind_i,
  input  logic [PixBits-1:0] pix_i,
  output logic               full_o,
  input  logic               restart_i,
  input  logic [WW-1:0]      w_i,
  input  logic [HW-1:0]      h_i,
  input  logic               q_full_i,
  output sem_job_t           job_o,
  output logic               job_push_o
);

  localparam int AW = $clog2(MaxWidth);
  localparam logic F_IDLE = 1'b0;
  localparam logic F_READ = 1'b1;

  logic state_q, state_d;
  logic [WW-1:0] col_q, col_d, drain_q, drain_d;
  logic [HW-1:0] row_q, row_d;
  sem_win_t win_q, win_d;

  logic kind_q, act_q, jz_q;
  logic [PixBits-1:0] pix_q;
  logic [WW-1:0] c_q, j_q;
  logic [HW-1:0] r_q;

  logic accept;
  logic [WW-1:0] c_cl, j_acc;
  logic [HW-1:0] r_cl;
  logic [AW-1:0] raddr;
  logic [PixBits-1:0] lo_rd, hi_rd;
  logic we;

  assign full_o = (state_q == F_READ) || q_full_i;
  assign accept = push_i && !full_o;

  assign c_cl  = (col_q >= w_i) ? '0 : col_q;
  assign r_cl  = (row_q >= h_i) ? '0 : row_q;
  assign j_acc = WW'(w_i + WW'(1) - drain_q);
  assign raddr = kind_i ? j_acc[AW-1:0] : c_cl[AW-1:0];

  // Low half holds the previous row, high half the row before it.
  sem_ram #(.Width(PixBits), .Depth(MaxWidth)) u_lo (
    .clk_i, .we_i(we), .waddr_i(c_q[AW-1:0]), .wdata_i(pix_q),
    .raddr_i(raddr), .rdata_o(lo_rd)
  );
  sem_ram #(.Width(PixBits), .Depth(MaxWidth)) u_hi (
    .clk_i, .we_i(we), .waddr_i(c_q[AW-1:0]), .wdata_i(lo_rd),
    .raddr_i(raddr), .rdata_o(hi_rd)
  );

  always_comb begin
    logic [PixBits-1:0] col_top, col_mid, col_bot;
    logic [WW-1:0] c1;
    logic [HW-1:0] r1;
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    drain_d    = drain_q;
    win_d      = win_q;
    we         = 1'b0;
    job_push_o = 1'b0;
    job_o      = '0;
    col_top    = '0;
    col_mid    = '0;
    col_bot    = '0;
    c1         = WW'(c_q + WW'(1));
    r1         = HW'(r_q + HW'(1));
    if (state_q == F_IDLE) begin
      if (accept) begin
        state_d = F_READ;
      end
    end else begin
      state_d = F_IDLE;
      if (!kind_q) begin
        we      = 1'b1;
        col_top = hi_rd;
        col_mid = lo_rd;
        col_bot = pix_q;
        drain_d = '0;
        col_d   = c1;
        row_d   = r_q;
        if (c1 >= w_i) begin
          col_d = '0;
          row_d = r1;
          if (r1 >= h_i) begin
            row_d   = '0;
            drain_d = WW'(w_i + WW'(1));
          end
        end
      end else if (act_q) begin
        col_top = jz_q ? '0 : hi_rd;
        col_mid = jz_q ? '0 : lo_rd;
        drain_d = WW'(drain_q - WW'(1));
      end
      if (!kind_q || act_q) begin
        for (int y = 0; y < 3; y++) begin
          win_d[y][0] = win_q[y][1];
          win_d[y][1] = win_q[y][2];
        end
        win_d[0][2] = col_top;
        win_d[1][2] = col_mid;
        win_d[2][2] = col_bot;
      end
      job_o.win = win_d;
      if (!kind_q) begin
        if (32'(c_q) >= 32'd1) begin
          job_push_o    = 32'(r_q) >= 32'd1;
          job_o.top_ok  = 32'(r_q) >= 32'd2;
          job_o.bot_ok  = 1'b1;
          job_o.lft_ok  = 32'(c_q) >= 32'd2;
          job_o.rgt_ok  = 1'b1;
        end else begin
          job_push_o    = 32'(r_q) >= 32'd2;
          job_o.top_ok  = 32'(r_q) >= 32'd3;
          job_o.bot_ok  = 1'b1;
          job_o.lft_ok  = 32'(w_i) >= 32'd2;
          job_o.rgt_ok  = 1'b0;
        end
      end else if (act_q) begin
        if (j_q == '0) begin
          job_push_o    = 32'(h_i) >= 32'd2;
          job_o.top_ok  = 32'(h_i) >= 32'd3;
          job_o.bot_ok  = 1'b1;
          job_o.lft_ok  = 32'(w_i) >= 32'd2;
          job_o.rgt_ok  = 1'b0;
        end else begin
          job_push_o      = 1'b1;
          job_o.top_ok    = 32'(h_i) >= 32'd2;
          job_o.bot_ok    = 1'b0;
          job_o.lft_ok    = 32'(j_q) >= 32'd2;
          job_o.rgt_ok    = j_q < w_i;
          job_o.frame_end = j_q == w_i;
        end
      end
    end
    if (restart_i) begin
      state_d    = F_IDLE;
      col_d      = '0;
      row_d      = '0;
      drain_d    = '0;
      win_d      = '0;
      we         = 1'b0;
      job_push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      win_q   <= win_d;
    end
  end

  // Hold the accepted word for the read cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      pix_q  <= pix_i;
      c_q    <= c_cl;
      r_q    <= r_cl;
      j_q    <= j_acc;
      act_q  <= drain_q != '0;
      jz_q   <= j_acc >= w_i;
    end
  end

  `SEM_ASSERT(a_no_push_full, clk_i, rst_ni, job_push_o |-> !q_full_i)
  `SEM_ASSERT_NEXT(a_read_one, clk_i, rst_ni, state_q == F_READ, state_q == F_IDLE)
  `SEM_ASSERT(a_drain_bound, clk_i, rst_ni, 32'(drain_q) <= 32'(w_i) + 32'd1)

endmodule

// ===== design/sem_jobq.sv =====
// Short job queue between front end and back end.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_jobq import sem_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sem_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output sem_job_t data_o,
  output logic     empty_o
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  sem_job_t slot_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : PW'(wp_q + PW'(1));
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : PW'(rp_q + PW'(1));
      end
      cnt_q <= CW'(cnt_q + CW'(do_push) - CW'(do_pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== design/sem_back.sv =====
// Back end: Sobel gradients, rounded square root per channel, result word.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_back import sem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  sem_job_t job_i,
  output logic     q_pop_o,
  output logic [7:0] edge_red_o,
  output logic [7:0] edge_green_o,
  output logic [7:0] edge_blue_o,
  output logic     frame_end_o,
  output logic     empty_o,
  input  logic     pop_i
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ   = 3'd1;
  localparam logic [2:0] B_ITER = 3'd2;
  localparam logic [2:0] B_RND  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0] state_q;
  logic signed [11:0] gx_q [3], gy_q [3], gx_c [3], gy_c [3];
  logic [20:0] s_q [3];
  logic [7:0]  n_q [3];
  logic [7:0]  mag_q [3];
  logic [7:0]  bit_q;
  logic        fe_q;
  logic        res_valid_q;
  logic [7:0]  res_q [3];
  logic        res_fe_q;
  logic        res_take;

  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign res_take = (state_q == B_OUT) && (!res_valid_q || pop_i);

  // Masked kernel sums; taps outside the image count as zero.
  always_comb begin
    int sx, sy, v;
    logic [2:0] row_ok, col_ok;
    row_ok = {job_i.bot_ok, 1'b1, job_i.top_ok};
    col_ok = {job_i.rgt_ok, 1'b1, job_i.lft_ok};
    for (int ch = 0; ch < 3; ch++) begin
      sx = 0;
      sy = 0;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          v = int'(job_i.win[y][x][23 - 8 * ch -: 8]);
          if (row_ok[y] && col_ok[x]) begin
            sx = sx + v * KX[y][x];
            sy = sy + v * KY[y][x];
          end
        end
      end
      gx_c[ch] = 12'(sx);
      gy_c[ch] = 12'(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      case (state_q)
        B_IDLE: if (!q_empty_i) state_q <= B_SQ;
        B_SQ: begin
          state_q <= B_ITER;
          bit_q   <= 8'h80;
        end
        B_ITER: begin
          bit_q <= bit_q >> 1;
          if (bit_q == 8'h01) state_q <= B_RND;
        end
        B_RND:  state_q <= B_OUT;
        B_OUT:  if (res_take) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
      if (res_take) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [7:0]  t;
    logic [15:0] tt, nn;
    logic [8:0]  rn;
    for (int ch = 0; ch < 3; ch++) begin
      t  = n_q[ch] | bit_q;
      tt = 16'(t) * 16'(t);
      nn = 16'(n_q[ch]) * 16'(n_q[ch]);
      rn = 9'(n_q[ch]) + 9'((s_q[ch] - 21'(nn)) > 21'(n_q[ch]));
      case (state_q)
        B_IDLE: begin
          gx_q[ch] <= gx_c[ch];
          gy_q[ch] <= gy_c[ch];
        end
        B_SQ: begin
          s_q[ch] <= 21'($unsigned(24'(gx_q[ch]) * 24'(gx_q[ch])))
                   + 21'($unsigned(24'(gy_q[ch]) * 24'(gy_q[ch])));
          n_q[ch] <= '0;
        end
        B_ITER: if (21'(tt) <= s_q[ch]) n_q[ch] <= t;
        B_RND: begin
          if (s_q[ch] > SatLimit || rn > 9'(PixMax)) mag_q[ch] <= PixMax;
          else mag_q[ch] <= rn[7:0];
        end
        default: ;
      endcase
      if (res_take) res_q[ch] <= mag_q[ch];
    end
    if (state_q == B_IDLE) fe_q <= job_i.frame_end;
    if (res_take) res_fe_q <= fe_q;
  end

  assign edge_red_o   = res_q[0];
  assign edge_green_o = res_q[1];
  assign edge_blue_o  = res_q[2];
  assign frame_end_o  = res_fe_q;
  assign empty_o      = !res_valid_q;

endmodule

// ===== design/sobel_edge_magnitude_rgb_core.sv =====
// Top level of the RGB Sobel edge magnitude core: config port, front end,
// job queue, back end. Depends on sem_pkg, sem_front, sem_jobq, sem_back.
`timescale 1ns / 1ps
// Usage:
//   Input channel: push a word (kind_i, in_*_i) while full is low. Pixels of
//   a frame come in raster order; after the frame push image_width+1 flush
//   words (kind_i = 1) to drain the last results. Extra flushes give nothing.
//   Result channel: while empty is low the oldest result word sits on
//   edge_*_o and frame_end_o; pop takes it. Results trail pixels by
//   image_width+1 positions.
//   Flow: the front end takes no new word while it handles the last one (line
//   buffer read, then window update and write-back), and none while the job
//   queue is full. The back end takes one job at a time (gradient, squares,
//   8 root steps of a bit-serial square root, rounding, output load). A 2-entry
//   job queue and the output register let each side stall on its own.
//   Config: APB writes at 0x0 (image_width) and 0x4 (image_height) restart
//   the frame; write only while the block is idle.
//   Reset: registers return to 640 x 480, counters and window to zero; line
//   buffers hold nothing defined and need no clearing pass.
//   A stalled receiver fills the output register, then the queue, then
//   raises full.
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  edge_red_o,
  output logic [7:0]  edge_green_o,
  output logic [7:0]  edge_blue_o,
  output logic        frame_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = $clog2(MaxWidth + 2);
  localparam int HW = $clog2(MaxHeight + 1);

  logic [CfgWidthBits-1:0]  cfg_w_q;
  logic [CfgHeightBits-1:0] cfg_h_q;
  logic cfg_we;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  sem_job_t job_in, job_out;
  logic job_push, q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Register index sits in paddr[2]; low address bits are don't-care.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= WidthReset;
      cfg_h_q <= HeightReset;
    end else if (cfg_we) begin
      if (paddr[2] == RegWidth) cfg_w_q <= pwdata[CfgWidthBits-1:0];
      else cfg_h_q <= pwdata[CfgHeightBits-1:0];
    end
  end

  assign prdata = (paddr[2] == RegHeight) ? 32'(cfg_h_q) : 32'(cfg_w_q);

  // Zero acts as one; values above the build limit clamp to it.
  always_comb begin
    if (cfg_w_q == '0) eff_w = WW'(1);
    else if (32'(cfg_w_q) > 32'(MaxWidth)) eff_w = WW'(MaxWidth);
    else eff_w = WW'(cfg_w_q);
    if (cfg_h_q == '0) eff_h = HW'(1);
    else if (32'(cfg_h_q) > 32'(MaxHeight)) eff_h = HW'(MaxHeight);
    else eff_h = HW'(cfg_h_q);
  end

  sem_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .kind_i, .pix_i({in_red_i, in_green_i, in_blue_i}),
    .full_o(full), .restart_i(cfg_we), .w_i(eff_w), .h_i(eff_h),
    .q_full_i(q_full), .job_o(job_in), .job_push_o(job_push)
  );

  sem_jobq #(.Depth(2)) u_jobq (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .full_o(q_full),
    .pop_i(q_pop), .data_o(job_out), .empty_o(q_empty)
  );

  sem_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .job_i(job_out), .q_pop_o(q_pop),
    .edge_red_o, .edge_green_o, .edge_blue_o, .frame_end_o,
    .empty_o(empty), .pop_i(pop)
  );

endmodule
